/* src/motor_speed_pi_regulator_core_defines.svh */
// Assertion macros for the motor speed PI regulator core.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef MOTOR_SPEED_PI_REGULATOR_CORE_DEFINES_SVH
`define MOTOR_SPEED_PI_REGULATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define MSR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSR_ASSERT(lbl, clk, rst, prop, msg)
`define MSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* src/msr_pkg.sv */
// Shared types and constants of the motor speed PI regulator core.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package msr_pkg;

   localparam int POS_W   = 32;
   localparam int DLT_W   = 33;
   localparam int SPD_W   = 24;
   localparam int ERR_W   = 25;
   localparam int DRV_W   = 8;
   localparam int K_W     = 16;
   localparam int T_W     = 16;
   localparam int MODE_W  = 2;
   localparam int IDX_W   = 2;
   localparam int CSR_W   = 24;
   localparam int SUM_W   = 32;
   localparam int DIV_W   = 35;
   localparam int Q_W     = 24;
   localparam int CNT_W   = 5;
   localparam int NUM_W   = 62;
   localparam int DEN_W   = 26;
   localparam int KE_W    = 42;
   localparam int KT_W    = 32;
   localparam int E10_W   = 29;
   localparam int K100_W  = 23;
   localparam int PT_W    = 24;
   localparam int B_W     = 56;
   localparam int C_W     = 34;
   localparam int NUM1_W  = 43;
   localparam int SPD_MAG_W  = 26;
   localparam int SPD_SHIFT  = 27;
   localparam int SPD_PROD_W = 51;

   localparam logic [MODE_W-1:0] MODE_STOP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_P    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PI   = 2'd2;

   localparam logic [IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_GAIN   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_TCONST = 2'd2;
   localparam logic [IDX_W-1:0] CSR_TARGET = 2'd3;

   localparam logic [CNT_W-1:0] DRV_STEPS = 5'd8;

   // Reciprocal of three scaled by two to the 27th, exact for magnitudes below 2**27.
   localparam logic [SPD_MAG_W-1:0] SPD_RECIP = 26'd44739243;
   localparam logic [DIV_W-1:0]     SPD_LIMIT = DIV_W'(3) << 24;

   localparam logic signed [SPD_W-1:0] SPEED_MAX = 24'sh7FFFFF;
   localparam logic signed [SPD_W-1:0] SPEED_MIN = 24'sh800000;
   localparam logic [Q_W-1:0]          SPEED_NEG_MAG = 24'h800000;

   localparam logic [DRV_W-1:0] DRIVE_MAX = 8'd255;
   localparam logic [DRV_W-1:0] DRIVE_MIN = 8'd0;

   typedef struct packed {
      logic load;
      logic mag;
      logic sdiv;
      logic speed;
      logic err;
      logic mul1;
      logic mul2;
      logic add1;
      logic add2;
      logic chk;
      logic ddiv;
      logic fin;
   } msr_cmd_type;

   typedef struct packed {
      logic div_done;
   } msr_stat_type;

endpackage

`default_nettype wire

/* src/motor_speed_pi_regulator_core.sv */
// Top level of the motor speed PI regulator core: controller, datapath and checks.
// Depends on msr_pkg, msr_ctrl, msr_datapath and the assertion macro header.
//
// Usage: every request transaction on req_ carries one encoder angle sampled at a
// control tick. The block converts the angle change to rpm, forms the speed error
// and updates the drive byte in stop, proportional or PI mode. Each request gives
// exactly one response transaction on rsp_ with speed, error and drive.
// Registers are written on the csr_ channel, index plus data, and csr_ready is
// always high. Registers should only change while no request is in flight.
// The speed is scaled by a reciprocal multiply in the SDIV state; the drive is
// then found by an 8-step division in the serial divider. One request is worked
// on at a time: a new request is accepted only once the previous one has been
// written to the response register and the controller is back in idle.
// A response waiting on a stalled receiver does not block the next
// request; only the final write of a new response waits for the output register.
// Synchronous reset clears the mode, gain and target, sets the time constant to
// one, and clears the last angle, the drive and the error sum.
`default_nettype none
`include "motor_speed_pi_regulator_core_defines.svh"

module motor_speed_pi_regulator_core
   import msr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [POS_W-1:0] req_encoder_position,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [SPD_W-1:0]      rsp_measured_speed,
   output logic signed [ERR_W-1:0]      rsp_speed_error,
   output logic        [DRV_W-1:0]      rsp_drive_value,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [IDX_W-1:0]        csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata
);

   msr_cmd_type  cmd;
   msr_stat_type stat;

   assign csr_ready = 1'b1;

   msr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msr_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_encoder_position (req_encoder_position),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_measured_speed   (rsp_measured_speed),
      .rsp_speed_error      (rsp_speed_error),
      .rsp_drive_value      (rsp_drive_value)
   );

   `MSR_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `MSR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready while busy")
   `MSR_ASSERT(a_fin_free, clock, reset, !cmd.fin || !rsp_valid || rsp_ready, "response overwritten")
   `MSR_ASSERT_NEXT(a_fin_valid, clock, reset, cmd.fin, rsp_valid, "result written without valid")

endmodule

`default_nettype wire

/* src/msr_div.sv */
// Restoring divider that produces a number of quotient bits set by the steps input, one per cycle.
// Depends on msr_pkg for widths.
`default_nettype none

module msr_div
   import msr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   input  wire logic [CNT_W-1:0] steps,
   output logic      [DRV_W-1:0] quotient,
   output logic                  done
);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [DRV_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic             fits;

   always_comb begin
      fits    = (rem_ff >= dsr_ff);
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         dsr_in = divisor;
         quo_in = '0;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         dsr_in  = dsr_ff >> 1;
         quo_in  = {quo_ff[DRV_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

/* src/msr_ctrl.sv */
// Sequencing state machine of the regulator: handshakes and datapath commands.
// Depends on msr_pkg for the command and status structs.
`default_nettype none

module msr_ctrl
   import msr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire msr_stat_type stat,
   output msr_cmd_type       cmd
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_MAG   = 13'b0000000000010,
      ST_SDIV  = 13'b0000000000100,
      ST_SPEED = 13'b0000000001000,
      ST_ERR   = 13'b0000000010000,
      ST_MUL1  = 13'b0000000100000,
      ST_MUL2  = 13'b0000001000000,
      ST_ADD1  = 13'b0000010000000,
      ST_ADD2  = 13'b0000100000000,
      ST_CHK   = 13'b0001000000000,
      ST_DDIV  = 13'b0010000000000,
      ST_DWAIT = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } msr_state_type;

   msr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_SDIV;
         end
         ST_SDIV: begin
            cmd.sdiv = 1'b1;
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.speed = 1'b1;
            state_in  = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            cmd.add1 = 1'b1;
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            cmd.add2 = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk  = 1'b1;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            cmd.ddiv = 1'b1;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (stat.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/msr_datapath.sv */
// Datapath of the regulator: control registers, loop state, arithmetic and result registers.
// Depends on msr_pkg and instantiates the msr_div divider.
`default_nettype none

module msr_datapath
   import msr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [IDX_W-1:0]        csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata,
   input  wire logic signed [POS_W-1:0] req_encoder_position,
   input  wire msr_cmd_type             cmd,
   output msr_stat_type                 stat,
   output logic signed [SPD_W-1:0]      rsp_measured_speed,
   output logic signed [ERR_W-1:0]      rsp_speed_error,
   output logic        [DRV_W-1:0]      rsp_drive_value
);

   logic        [MODE_W-1:0] mode_ff;
   logic        [K_W-1:0]    gain_ff;
   logic        [T_W-1:0]    tconst_ff;
   logic signed [SPD_W-1:0]  target_ff;

   logic signed [POS_W-1:0]  last_pos_ff;
   logic        [DRV_W-1:0]  prev_drv_ff, prev_drv_in;
   logic signed [SUM_W-1:0]  err_sum_ff;

   logic signed [DLT_W-1:0]  delta_ff;
   logic        [DLT_W-1:0]  abs_delta;
   logic        [DIV_W-1:0]  mag_ff;
   logic                     neg_ff;
   logic        [SPD_PROD_W-1:0] spd_prod;
   logic        [Q_W-1:0]    spd_q_ff;
   logic signed [SPD_W-1:0]  speed_ff, speed_in;
   logic signed [ERR_W-1:0]  err_ff;

   logic        [T_W-1:0]    teff;
   logic signed [KE_W-1:0]   ke_ff;
   logic        [KT_W-1:0]   kt_ff;
   logic signed [E10_W-1:0]  e10_ff;
   logic        [K100_W-1:0] k100_ff;
   logic        [PT_W-1:0]   pt_ff;
   logic        [DEN_W-1:0]  t1000_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W:0]    sum_wide;

   logic signed [NUM_W-1:0]  a_ff;
   logic signed [B_W-1:0]    b_ff;
   logic        [C_W-1:0]    c_ff;
   logic signed [NUM1_W-1:0] num1_ff;
   logic signed [NUM_W-1:0]  ab_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic        [DEN_W-1:0]  den_ff;
   logic                     nneg_ff;
   logic                     big_ff;

   logic                     div_start;
   logic        [DIV_W-1:0]  div_dividend;
   logic        [DIV_W-1:0]  div_divisor;
   logic        [CNT_W-1:0]  div_steps;
   logic        [DRV_W-1:0]  div_q;
   logic                     div_done;
   logic                     spd_sat;

   msr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .quotient (div_q),
      .done     (div_done)
   );

   always_comb begin
      div_start    = cmd.ddiv;
      div_dividend = DIV_W'($unsigned(num_ff[C_W:0]));
      div_divisor  = DIV_W'({den_ff, 7'b0});
      div_steps    = DRV_STEPS;
      stat.div_done = div_done;
   end

   always_comb begin
      abs_delta = delta_ff[DLT_W-1] ? DLT_W'(-delta_ff) : DLT_W'(delta_ff);
      teff      = (tconst_ff == '0) ? T_W'(1) : tconst_ff;
      spd_sat   = (mag_ff >= SPD_LIMIT);
      spd_prod  = SPD_PROD_W'(mag_ff[SPD_MAG_W-1:0]) * SPD_PROD_W'(SPD_RECIP);
      if (!neg_ff) begin
         speed_in = (spd_sat || spd_q_ff[Q_W-1]) ? SPEED_MAX
                                                 : $signed({1'b0, spd_q_ff[Q_W-2:0]});
      end else begin
         speed_in = (spd_sat || (spd_q_ff > SPEED_NEG_MAG)) ? SPEED_MIN : $signed(-spd_q_ff);
      end
      sum_wide = (SUM_W+1)'(err_sum_ff) + (SUM_W+1)'(err_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                                  : $signed({1'b0, {(SUM_W-1){1'b1}}});
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
      case (mode_ff)
         MODE_P, MODE_PI: begin
            if (!nneg_ff) begin
               prev_drv_in = DRIVE_MIN;
            end else if (big_ff) begin
               prev_drv_in = DRIVE_MAX;
            end else begin
               prev_drv_in = div_q;
            end
         end
         default: begin
            prev_drv_in = prev_drv_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STOP;
         gain_ff     <= '0;
         tconst_ff   <= T_W'(1);
         target_ff   <= '0;
         last_pos_ff <= '0;
         prev_drv_ff <= '0;
         err_sum_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
               CSR_GAIN:   gain_ff   <= csr_wdata[K_W-1:0];
               CSR_TCONST: tconst_ff <= csr_wdata[T_W-1:0];
               CSR_TARGET: target_ff <= $signed(csr_wdata[SPD_W-1:0]);
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            last_pos_ff <= req_encoder_position;
         end
         if (cmd.fin) begin
            prev_drv_ff <= prev_drv_in;
            if (mode_ff == MODE_PI) begin
               err_sum_ff <= sum_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delta_ff <= DLT_W'(req_encoder_position) - DLT_W'(last_pos_ff);
      end
      if (cmd.mag) begin
         mag_ff <= (DIV_W'(abs_delta) << 2) + DIV_W'(abs_delta);
         neg_ff <= delta_ff[DLT_W-1];
      end
      if (cmd.sdiv) begin
         spd_q_ff <= spd_prod[SPD_SHIFT +: Q_W];
      end
      if (cmd.speed) begin
         speed_ff <= speed_in;
      end
      if (cmd.err) begin
         err_ff <= ERR_W'(target_ff) - ERR_W'(speed_ff);
      end
      if (cmd.mul1) begin
         ke_ff    <= KE_W'($signed({1'b0, gain_ff})) * KE_W'(err_ff);
         kt_ff    <= KT_W'(gain_ff) * KT_W'(teff);
         e10_ff   <= E10_W'(err_ff) * E10_W'(10);
         k100_ff  <= K100_W'(gain_ff) * K100_W'(100);
         pt_ff    <= PT_W'(prev_drv_ff) * PT_W'(teff);
         t1000_ff <= DEN_W'(teff) * DEN_W'(1000);
         sum_ff   <= sum_in;
      end
      if (cmd.mul2) begin
         a_ff    <= NUM_W'($signed({1'b0, kt_ff})) * NUM_W'(e10_ff);
         b_ff    <= B_W'($signed({1'b0, k100_ff})) * B_W'(sum_ff);
         c_ff    <= C_W'(pt_ff) * C_W'(1000);
         num1_ff <= NUM1_W'($signed({1'b0, prev_drv_ff})) * NUM1_W'(100) + NUM1_W'(ke_ff);
      end
      if (cmd.add1) begin
         ab_ff <= a_ff + NUM_W'(b_ff);
      end
      if (cmd.add2) begin
         if (mode_ff == MODE_PI) begin
            num_ff <= ab_ff + NUM_W'($signed({1'b0, c_ff}));
            den_ff <= t1000_ff;
         end else begin
            num_ff <= NUM_W'(num1_ff);
            den_ff <= DEN_W'(100);
         end
      end
      if (cmd.chk) begin
         nneg_ff <= !num_ff[NUM_W-1];
         big_ff  <= ($unsigned(num_ff) >= NUM_W'({den_ff, 8'b0}));
      end
      if (cmd.fin) begin
         rsp_measured_speed <= speed_ff;
         rsp_speed_error    <= err_ff;
         rsp_drive_value    <= prev_drv_in;
      end
   end

endmodule

`default_nettype wire

/* verif/tb_motor_speed_pi_regulator_core.sv */
// Self-checking testbench of the motor speed PI regulator core: directed and random angle
// sequences over stop, P and PI settings, checked against a built-in cycle-free predictor.
// Depends on msr_pkg and the motor_speed_pi_regulator_core RTL.
`timescale 1ns / 1ps

module tb_motor_speed_pi_regulator_core
   import msr_pkg::*;
();

   localparam int RUN_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic signed [SPD_W-1:0] measured_speed;
      logic signed [ERR_W-1:0] speed_error;
      logic [DRV_W-1:0]        drive_value;
   } tick_report_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [POS_W-1:0] req_encoder_position = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [SPD_W-1:0] rsp_measured_speed;
   logic signed [ERR_W-1:0] rsp_speed_error;
   logic [DRV_W-1:0]        rsp_drive_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   // Register copies and regulator state as the predictor sees them.
   logic [MODE_W-1:0]       reg_mode = MODE_STOP;
   logic [K_W-1:0]          reg_gain = '0;
   logic [T_W-1:0]          reg_tconst = 16'd1;
   logic signed [SPD_W-1:0] reg_target = '0;
   logic signed [POS_W-1:0] last_angle = '0;
   logic [DRV_W-1:0]        last_drive = '0;
   logic signed [SUM_W-1:0] error_total = '0;

   logic signed [POS_W-1:0] encoder_angles[$];
   tick_report_type         drive_reports[$];

   logic req_accepted = 1'b0;
   logic req_gaps_on = 1'b1;
   logic rsp_stalls_on = 1'b1;
   logic hold_trigger = 1'b0;
   logic hold_taken = 1'b0;
   int   req_gap_left = 0;
   int   rsp_hold_left = 0;
   int   fail_count = 0;
   int   cycle_count = 0;

   motor_speed_pi_regulator_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_encoder_position (req_encoder_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_measured_speed   (rsp_measured_speed),
      .rsp_speed_error      (rsp_speed_error),
      .rsp_drive_value      (rsp_drive_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   // Computes speed, error and drive for one tick and advances the regulator state.
   function automatic tick_report_type regulate_tick(logic signed [POS_W-1:0] angle);
      tick_report_type report;
      longint delta, rpm, err, drive, gain, tc, total, num;
      delta = longint'(angle) - longint'(last_angle);
      rpm = (delta * 5) / 3;
      if (rpm > longint'(SPEED_MAX)) rpm = longint'(SPEED_MAX);
      if (rpm < longint'(SPEED_MIN)) rpm = longint'(SPEED_MIN);
      err = longint'(reg_target) - rpm;
      last_angle = angle;
      drive = longint'(last_drive);
      gain = longint'(reg_gain);
      case (reg_mode)
         MODE_P: begin
            drive = (drive * 100 + gain * err) / 100;
         end
         MODE_PI: begin
            tc = (reg_tconst == '0) ? 1 : longint'(reg_tconst);
            total = longint'(error_total) + err;
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            if (total < -64'sd2147483648) total = -64'sd2147483648;
            error_total = total[SUM_W-1:0];
            num = drive * 1000 * tc + gain * err * 10 * tc + gain * total * 100;
            drive = num / (1000 * tc);
         end
         default: begin
         end
      endcase
      if (drive > longint'(DRIVE_MAX)) drive = longint'(DRIVE_MAX);
      if (drive < 0) drive = 0;
      last_drive = drive[DRV_W-1:0];
      report.measured_speed = rpm[SPD_W-1:0];
      report.speed_error = err[ERR_W-1:0];
      report.drive_value = drive[DRV_W-1:0];
      return report;
   endfunction

   // Request driver: payload changes on the falling edge; gaps, when on, follow transactions.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         req_valid <= 1'b1;
      end else if (req_gap_left > 0) begin
         req_valid <= 1'b0;
         req_gap_left--;
      end else if (encoder_angles.size() > 0) begin
         req_valid <= 1'b1;
         req_encoder_position <= encoder_angles.pop_front();
         req_gap_left = req_gaps_on ? pick_gap() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_accepted <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         drive_reports.push_back(regulate_tick(req_encoder_position));
      end
   end

   // Response side: random stalls plus one long hold-off so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (hold_trigger && !hold_taken) begin
         hold_taken = 1'b1;
         rsp_hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_hold_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tick_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_reports.size() == 0) begin
            $error("response transaction arrived with no expected result");
            fail_count++;
         end else begin
            want = drive_reports.pop_front();
            if (rsp_measured_speed !== want.measured_speed) begin
               $error("measured_speed: expected %0d, actual %0d",
                      want.measured_speed, rsp_measured_speed);
               fail_count++;
            end
            if (rsp_speed_error !== want.speed_error) begin
               $error("speed_error: expected %0d, actual %0d",
                      want.speed_error, rsp_speed_error);
               fail_count++;
            end
            if (rsp_drive_value !== want.drive_value) begin
               $error("drive_value: expected %0d, actual %0d",
                      want.drive_value, rsp_drive_value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic write_register(input logic [IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MODE:   reg_mode = data[MODE_W-1:0];
         CSR_GAIN:   reg_gain = data[K_W-1:0];
         CSR_TCONST: reg_tconst = data[T_W-1:0];
         CSR_TARGET: reg_target = data;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (encoder_angles.size() != 0 || req_valid || drive_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic signed [POS_W-1:0] angle;
      logic [CSR_W-1:0]        junk;
      logic [CSR_W-1:0]        target;
      logic [MODE_W-1:0]       mode;
      logic [K_W-1:0]          gain;
      logic [T_W-1:0]          tconst;
      int                      span;
      int                      pick;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Stop mode from reset: first tick against angle zero, truncation, saturation.
      encoder_angles = '{32'sd0, 32'sd3, -32'sd3, -32'sd2, -32'sd3,
                         32'sh7FFFFFFF, 32'sh80000000};
      wait_idle();

      write_register(CSR_MODE, CSR_W'(MODE_P));
      write_register(CSR_GAIN, 24'd100);
      write_register(CSR_TCONST, 24'd65535);
      write_register(CSR_TARGET, 24'd10);
      encoder_angles = '{32'sd0, 32'sd0, 32'sd6, 32'sd6, 32'sd0};
      wait_idle();
      write_register(CSR_GAIN, 24'd65535);
      write_register(CSR_TARGET, 24'h7FFFFF);
      encoder_angles = '{32'sd0, 32'sd0};
      wait_idle();
      write_register(CSR_TARGET, 24'h800000);
      encoder_angles = '{32'sd0, 32'sd0};
      wait_idle();

      // PI mode with a zero time constant, then the unused mode code.
      write_register(CSR_MODE, CSR_W'(MODE_PI));
      write_register(CSR_GAIN, 24'd3);
      write_register(CSR_TCONST, 24'd0);
      write_register(CSR_TARGET, 24'd100);
      encoder_angles = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
      wait_idle();
      write_register(CSR_MODE, CSR_W'(MODE_UNUSED));
      encoder_angles = '{32'sd50, -32'sd50};
      wait_idle();

      // Steady full-speed rotation against the opposite target drives the error sum
      // into negative saturation.
      write_register(CSR_MODE, CSR_W'(MODE_PI));
      write_register(CSR_GAIN, CSR_W'($urandom_range(1, 20)));
      write_register(CSR_TCONST, 24'd65535);
      write_register(CSR_TARGET, 24'h800000);
      req_gaps_on = 1'b0;
      angle = -32'sd2000000000;
      for (int n = 0; n < 135; n++) begin
         angle += 6000000 + int'($urandom_range(0, 1000));
         encoder_angles.push_back(angle);
      end
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: span = 3;
            1: span = 60;
            2: span = 3000;
            default: span = 600000;
         endcase
         mode = (phase % 2 == 0) ? MODE_PI : MODE_P;
         if ($urandom_range(0, 5) == 0) mode = MODE_UNUSED;
         case ($urandom_range(0, 3))
            0: gain = '0;
            1: gain = 16'hFFFF;
            2: gain = K_W'($urandom_range(1, 400));
            default: gain = K_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: tconst = '0;
            1: tconst = 16'd1;
            2: tconst = 16'hFFFF;
            default: tconst = T_W'($urandom_range(1, 50));
         endcase
         case ($urandom_range(0, 5))
            0: target = 24'h7FFFFF;
            1: target = 24'h800000;
            2: target = CSR_W'($urandom);
            default: target = CSR_W'(int'($urandom_range(0, 4 * span)) - 2 * span);
         endcase
         junk = CSR_W'($urandom);
         write_register(CSR_MODE, {junk[CSR_W-1:MODE_W], mode});
         write_register(CSR_GAIN, {junk[CSR_W-1:K_W], gain});
         write_register(CSR_TCONST, {junk[CSR_W-1:T_W], tconst});
         write_register(CSR_TARGET, target);
         if (phase == 2) begin
            req_gaps_on = 1'b0;
            hold_trigger = 1'b1;
         end
         angle = last_angle;
         for (int n = 0; n < 45; n++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               angle = POS_W'($urandom);
            end else if (pick == 1) begin
               angle = ($urandom_range(0, 1) == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            end else begin
               angle += int'($urandom_range(0, 2 * span)) - span;
            end
            encoder_angles.push_back(angle);
         end
         wait_idle();
      end

      if (drive_reports.size() != 0) begin
         $error("%0d expected results never arrived", drive_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
